// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the frame deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication check: when the condition holds, the consequence must hold.
`define ASSERT_IMP(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/tlfd_pkg.sv -----
// Constants, codes and address helpers for the frame deframer.
package tlfd_pkg;

  // Byte store geometry.
  localparam int STORE_BYTES = 512;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FILL_W      = $clog2(STORE_BYTES + 1);
  localparam int SUM_W       = ADDR_W + 1;

  // Frame layout.
  localparam int BYTE_W         = 8;
  localparam int TOTAL_W        = BYTE_W + 1;
  localparam int FRAME_OVERHEAD = 5;
  localparam int MEAS_LEN       = 4;
  localparam int TYPE_MIN       = 1;
  localparam int TYPE_MAX       = 5;
  localparam int WORD_W         = 32;
  localparam int MAX_RESULTS    = 52;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  // Register reset values.
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h55;

  // Configuration register indexes.
  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_TAIL   = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_MEAS     = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_TAIL     = 3'd4;

  // Circular address: base plus an offset below the store size, wrapped once.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [SUM_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= SUM_W'(STORE_BYTES)) begin
      sum = sum - SUM_W'(STORE_BYTES);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- src/typed_length_frame_deframer.sv -----
// Top level of the typed length frame deframer: byte store, sequencer and result stage.

// Received bytes are written into a circular byte store and a small sequencer
// works through the store over its single read port, whose read data is
// registered. After each byte transfer the block is busy until the sequencer
// is idle again: it discards each non-header byte, drops only the header byte
// of each frame with a bad tail, and for each frame whose tail matches reads
// the length, type and tail, makes a checksum pass of one byte per cycle and
// classifies the frame. A waiting result that the result channel stalls keeps
// it busy longer. At most 52 frames are decided per input byte. Results leave
// through an output register and a one-deep holding stage, so the last flag of
// a byte's final result is known before it is shown. The store needs no
// clearing after reset.
`include "assert_macros.svh"

module typed_length_frame_deframer
  import tlfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [BYTE_W-1:0]   cfg_data_i,
  // Byte input channel.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          status_o,
  output logic [BYTE_W-1:0]   frame_type_o,
  output logic [WORD_W-1:0]   payload_word_o,
  output logic                last_o
);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_LEN      = 4'd3;
  localparam logic [3:0] S_TYPE     = 4'd4;
  localparam logic [3:0] S_TAIL     = 4'd5;
  localparam logic [3:0] S_SUM      = 4'd6;
  localparam logic [3:0] S_CHK      = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  // Byte store and its registered read data.
  logic [BYTE_W-1:0] store_mem [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [TOTAL_W-1:0] rd_off;

  // Control state.
  logic [3:0]         state_q, state_d;
  logic [ADDR_W-1:0]  rp_q, rp_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0]  header_q, header_d;
  logic [BYTE_W-1:0]  tail_q, tail_d;

  // Frame work registers.
  logic [BYTE_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0]  type_q, type_d;
  logic [TOTAL_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0]  chk_q, chk_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [2:0]         res_status_q, res_status_d;

  // Holding stage and output register.
  logic               pend_v_q, pend_v_d;
  logic [2:0]         pend_status_q, pend_status_d;
  logic [BYTE_W-1:0]  pend_type_q, pend_type_d;
  logic [WORD_W-1:0]  pend_word_q, pend_word_d;
  logic               out_v_q, out_v_d;
  logic [2:0]         out_status_q, out_status_d;
  logic [BYTE_W-1:0]  out_type_q, out_type_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;
  logic               out_last_q, out_last_d;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] drop_n;
  logic               out_free;
  logic               in_xfer;

  assign total    = TOTAL_W'(len_q) + TOTAL_W'(FRAME_OVERHEAD);
  assign out_free = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer  = in_valid_i && in_ready_o;

  assign wr_addr = wrap_add(rp_q, SUM_W'(fill_q));
  assign rd_addr = wrap_add(rp_q, SUM_W'(rd_off));
  assign mem_we  = in_xfer && (fill_q < FILL_W'(STORE_BYTES));

  // Store write on a byte transfer while the store is not full, and registered read every cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wr_addr] <= rx_byte_i;
    end
    rdata_q <= store_mem[rd_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d       = state_q;
    rp_d          = rp_q;
    fill_d        = fill_q;
    cnt_d         = cnt_q;
    header_d      = header_q;
    tail_d        = tail_q;
    len_d         = len_q;
    type_d        = type_q;
    idx_d         = idx_q;
    chk_d         = chk_q;
    word_d        = word_q;
    res_status_d  = res_status_q;
    pend_v_d      = pend_v_q;
    pend_status_d = pend_status_q;
    pend_type_d   = pend_type_q;
    pend_word_d   = pend_word_q;
    out_v_d       = out_v_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_type_d    = out_type_q;
    out_word_d    = out_word_q;
    out_last_d    = out_last_q;
    rd_off        = '0;
    drop_n        = '0;

    // The user must write configuration only while idle; the block does not enforce it.
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEADER: header_d = cfg_data_i;
        CFG_TAIL:   tail_d   = cfg_data_i;
        default:    header_d = header_q;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (mem_we) begin
            fill_d = fill_q + FILL_W'(1);
          end
          cnt_d   = '0;
          state_d = S_SCAN_RD;
        end
      end

      // Look at the oldest stored byte.
      S_SCAN_RD: begin
        rd_off  = '0;
        state_d = (fill_q == '0) ? S_FINISH : S_SCAN_CHK;
      end

      // Discard a non-header byte, stop while fewer than three bytes are stored, or go on to the length byte.
      S_SCAN_CHK: begin
        if (rdata_q != header_q) begin
          drop_n  = TOTAL_W'(1);
          state_d = S_SCAN_RD;
        end else if (fill_q < FILL_W'(3)) begin
          state_d = S_FINISH;
        end else begin
          rd_off  = TOTAL_W'(2);
          state_d = S_LEN;
        end
      end

      // Wait until the whole frame is stored.
      S_LEN: begin
        len_d = rdata_q;
        if (fill_q < FILL_W'(TOTAL_W'(rdata_q) + TOTAL_W'(FRAME_OVERHEAD))) begin
          state_d = S_FINISH;
        end else begin
          rd_off  = TOTAL_W'(1);
          state_d = S_TYPE;
        end
      end

      S_TYPE: begin
        type_d  = rdata_q;
        rd_off  = total - TOTAL_W'(1);
        state_d = S_TAIL;
      end

      // A bad tail drops only the header byte; a good one starts the checksum.
      S_TAIL: begin
        if (rdata_q != tail_q) begin
          res_status_d = ST_TAIL;
          drop_n       = TOTAL_W'(1);
          state_d      = S_EMIT;
        end else begin
          idx_d   = '0;
          chk_d   = '0;
          word_d  = '0;
          rd_off  = '0;
          state_d = S_SUM;
        end
      end

      // One byte of the checksum pass per cycle; payload bytes 0 to 3 are kept.
      S_SUM: begin
        chk_d = chk_q ^ rdata_q;
        case (idx_q)
          TOTAL_W'(3): word_d[7:0]   = rdata_q;
          TOTAL_W'(4): word_d[15:8]  = rdata_q;
          TOTAL_W'(5): word_d[23:16] = rdata_q;
          TOTAL_W'(6): word_d[31:24] = rdata_q;
          default:     word_d        = word_q;
        endcase
        if (idx_q == total - TOTAL_W'(3)) begin
          rd_off  = total - TOTAL_W'(2);
          state_d = S_CHK;
        end else begin
          idx_d   = idx_q + TOTAL_W'(1);
          rd_off  = idx_q + TOTAL_W'(1);
        end
      end

      // Compare the checksum and classify the frame.
      S_CHK: begin
        if (chk_q != rdata_q) begin
          res_status_d = ST_CHECKSUM;
        end else if (type_q >= BYTE_W'(TYPE_MIN) && type_q <= BYTE_W'(TYPE_MAX)) begin
          res_status_d = (len_q == BYTE_W'(MEAS_LEN)) ? ST_MEAS : ST_BAD_LEN;
        end else begin
          res_status_d = ST_UNKNOWN;
        end
        drop_n  = total;
        state_d = S_EMIT;
      end

      // Push the held result out and hold the new one.
      S_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d      = 1'b1;
            out_status_d = pend_status_q;
            out_type_d   = pend_type_q;
            out_word_d   = pend_word_q;
            out_last_d   = 1'b0;
          end
          pend_v_d      = 1'b1;
          pend_status_d = res_status_q;
          pend_type_d   = type_q;
          pend_word_d   = (res_status_q == ST_MEAS) ? word_q : '0;
          cnt_d         = cnt_q + CNT_W'(1);
          state_d = (cnt_q + CNT_W'(1) == CNT_W'(MAX_RESULTS)) ? S_FINISH : S_SCAN_RD;
        end
      end

      // The held result is the final one of this byte.
      S_FINISH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_v_d      = 1'b1;
          out_status_d = pend_status_q;
          out_type_d   = pend_type_q;
          out_word_d   = pend_word_q;
          out_last_d   = 1'b1;
          pend_v_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Drop bytes from the front of the store.
    if (drop_n != '0) begin
      rp_d   = wrap_add(rp_q, SUM_W'(drop_n));
      fill_d = fill_q - FILL_W'(drop_n);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rp_q     <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      header_q <= HEADER_RESET;
      tail_q   <= TAIL_RESET;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rp_q     <= rp_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      header_q <= header_d;
      tail_q   <= tail_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q         <= len_d;
    type_q        <= type_d;
    idx_q         <= idx_d;
    chk_q         <= chk_d;
    word_q        <= word_d;
    res_status_q  <= res_status_d;
    pend_status_q <= pend_status_d;
    pend_type_q   <= pend_type_d;
    pend_word_q   <= pend_word_d;
    out_status_q  <= out_status_d;
    out_type_q    <= out_type_d;
    out_word_q    <= out_word_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = out_status_q;
  assign frame_type_o   = out_type_q;
  assign payload_word_o = out_word_q;
  assign last_o         = out_last_q;

  // The store never holds more bytes than it has entries.
  `ASSERT_CLK(a_fill_bound, fill_q <= FILL_W'(STORE_BYTES), "fill count above store size")
  // No result may be left held once the block takes a new byte.
  `ASSERT_IMP(a_idle_no_pend, state_q == S_IDLE, !pend_v_q, "held result left while idle")
  // The per-byte decision count stays within its limit.
  `ASSERT_CLK(a_cnt_bound, cnt_q <= CNT_W'(MAX_RESULTS), "decision count above limit")
  // A held result never stays behind when the block goes idle after finishing.
  `ASSERT_IMP(a_finish_out, state_q == S_FINISH && pend_v_q && out_free,
              ##1 out_v_q && out_last_q, "final result not shown")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the typed length frame deframer.
module tb;
  import tlfd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // After the last result the block may still rescan a backlog of up to about
  // 260 stored bytes, so settle() waits SETTLE_CYCLES after the results drain.
  localparam int SETTLE_CYCLES = 1200;

  typedef struct packed {
    logic [2:0]        status;
    logic [BYTE_W-1:0] frame_type;
    logic [WORD_W-1:0] payload_word;
    logic              last;
  } frame_result_t;

  // One input byte; a pinned row carries its one result written out by hand.
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              pinned;
    frame_result_t     want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = CFG_HEADER;
  logic [BYTE_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        status_o;
  logic [BYTE_W-1:0] frame_type_o;
  logic [WORD_W-1:0] payload_word_o;
  logic              last_o;

  typed_length_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_type_o   (frame_type_o),
    .payload_word_o (payload_word_o),
    .last_o         (last_o)
  );

  // Free-running 50 MHz clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mirror of the block: circular byte store and the two match registers.
  logic [BYTE_W-1:0] ring_mem [STORE_BYTES];
  int                ring_head = 0;
  int                ring_fill = 0;
  logic [BYTE_W-1:0] hdr_byte = HEADER_RESET;
  logic [BYTE_W-1:0] tail_byte = TAIL_RESET;

  frame_result_t pending_results [$];
  stim_row_t     byte_plan [$];
  frame_result_t oldest_result;

  int mismatches = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int limit_hits = 0;
  int status_seen [8] = '{default: 0};
  int cycle_count = 0;

  function automatic logic [BYTE_W-1:0] ring_at(input int k);
    return ring_mem[(ring_head + k) % STORE_BYTES];
  endfunction

  task automatic ring_drop(input int n);
    if (n > ring_fill) begin
      n = ring_fill;
    end
    ring_head = (ring_head + n) % STORE_BYTES;
    ring_fill -= n;
  endtask

  // Store one received byte, then decide every complete frame at the head of
  // the store, up to the per-byte decision cap, queuing one result for each.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, output int made);
    int            len;
    int            total;
    int            i;
    logic [BYTE_W-1:0] sum;
    frame_result_t res;
    made = 0;
    if (ring_fill < STORE_BYTES) begin
      ring_mem[(ring_head + ring_fill) % STORE_BYTES] = b;
      ring_fill++;
    end
    while (made < MAX_RESULTS) begin
      while (ring_fill > 0 && ring_at(0) != hdr_byte) begin
        ring_drop(1);
      end
      if (ring_fill < 3) begin
        break;
      end
      len = int'(ring_at(2));
      total = FRAME_OVERHEAD + len;
      if (ring_fill < total) begin
        break;
      end
      res = '0;
      res.frame_type = ring_at(1);
      if (ring_at(total - 1) != tail_byte) begin
        // A bad tail costs only the header byte; the rest is scanned again.
        res.status = ST_TAIL;
        ring_drop(1);
      end else begin
        sum = '0;
        for (i = 0; i < total - 2; i++) begin
          sum ^= ring_at(i);
        end
        if (sum != ring_at(total - 2)) begin
          res.status = ST_CHECKSUM;
        end else if (res.frame_type >= TYPE_MIN && res.frame_type <= TYPE_MAX) begin
          if (len == MEAS_LEN) begin
            res.status = ST_MEAS;
            res.payload_word = {ring_at(6), ring_at(5), ring_at(4), ring_at(3)};
          end else begin
            res.status = ST_BAD_LEN;
          end
        end else begin
          res.status = ST_UNKNOWN;
        end
        ring_drop(total);
      end
      pending_results.push_back(res);
      made++;
    end
    if (made > 0) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
    end
    if (made == MAX_RESULTS) begin
      limit_hits++;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic stim_row_t row(input logic [BYTE_W-1:0] b);
    stim_row_t r;
    r = '0;
    r.rx = b;
    return r;
  endfunction

  function automatic stim_row_t pin(input logic [BYTE_W-1:0] b, input logic [2:0] st,
                                    input logic [BYTE_W-1:0] ty,
                                    input logic [WORD_W-1:0] w);
    stim_row_t r;
    r = row(b);
    r.pinned = 1'b1;
    r.want.status = st;
    r.want.frame_type = ty;
    r.want.payload_word = w;
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    do begin
      v = BYTE_W'($urandom_range(0, 255));
    end while (v == a || v == b);
    return v;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_plan.push_back(row(b));
  endtask

  // Append one frame under the current header and tail, optionally corrupted.
  task automatic push_frame(input logic [BYTE_W-1:0] ftype, input int len,
                            input bit bad_sum, input bit bad_tail);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] p;
    sum = hdr_byte ^ ftype ^ BYTE_W'(len);
    push_byte(hdr_byte);
    push_byte(ftype);
    push_byte(BYTE_W'(len));
    repeat (len) begin
      p = BYTE_W'($urandom_range(0, 255));
      sum ^= p;
      push_byte(p);
    end
    if (bad_sum) begin
      sum ^= BYTE_W'($urandom_range(1, 255));
    end
    push_byte(sum);
    push_byte(bad_tail ? tail_byte ^ BYTE_W'($urandom_range(1, 255)) : tail_byte);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Feed the planned bytes in bursts of random length with random gaps.
  // When drain_at is reached the sender holds off until all results are in.
  task automatic stream_bytes(input int drain_at);
    int        burst;
    int        made;
    int        sent;
    stim_row_t r;
    sent = 0;
    burst = $urandom_range(1, 8);
    while (byte_plan.size() > 0) begin
      r = byte_plan.pop_front();
      in_valid_i <= 1'b1;
      rx_byte_i <= r.rx;
      @(posedge clk_i);
      while (!in_ready_o) begin
        @(posedge clk_i);
      end
      deframe_byte(r.rx, made);
      if (r.pinned) begin
        repeat (made) void'(pending_results.pop_back());
        pending_results.push_back(r.want);
      end
      bytes_sent++;
      sent++;
      burst--;
      if (sent == drain_at) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        drain_results();
        burst = $urandom_range(1, 8);
      end else if (burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 8);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // One setting of the match registers followed by a random byte stream.
  task automatic run_phase(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] tl,
                           input int nbytes, input bit with_burst, input int drain_at);
    int                pick;
    int                len;
    int                reps;
    logic [BYTE_W-1:0] ftype;
    settle();
    // Both registers change on consecutive edges while the block is idle.
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_HEADER;
    cfg_data_i <= hdr;
    @(posedge clk_i);
    cfg_index_i <= CFG_TAIL;
    cfg_data_i <= tl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_byte = hdr;
    tail_byte = tl;

    if (with_burst) begin
      // A long frame whose payload is all header bytes. Its tail fails, and each
      // header inside then opens a short frame with a bad tail, which is more
      // decisions than one byte may make; the rest spill into later bytes.
      reps = int'(hdr) + 56;
      push_byte(hdr);
      push_byte(hdr);
      push_byte(BYTE_W'(reps));
      repeat (reps) push_byte(hdr);
      push_byte(other_byte(hdr, tl));
      push_byte(other_byte(hdr, tl));
    end

    while (byte_plan.size() < nbytes) begin
      pick = $urandom_range(0, 99);
      ftype = BYTE_W'($urandom_range(TYPE_MIN, TYPE_MAX));
      if (pick < 45) begin
        push_frame(ftype, MEAS_LEN, 1'b0, 1'b0);
      end else if (pick < 57) begin
        len = $urandom_range(0, 12);
        if (len == MEAS_LEN) begin
          len++;
        end
        push_frame(ftype, len, 1'b0, 1'b0);
      end else if (pick < 62) begin
        push_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(13, 40), 1'b0, 1'b0);
      end else if (pick < 70) begin
        ftype = ($urandom_range(0, 1) == 0) ? '0 :
                BYTE_W'($urandom_range(TYPE_MAX + 1, 255));
        push_frame(ftype, $urandom_range(0, 8), 1'b0, 1'b0);
      end else if (pick < 78) begin
        push_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b1, 1'b0);
      end else if (pick < 86) begin
        push_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 6), 1'b0, 1'b1);
      end else if (pick < 95) begin
        // Line noise between frames.
        repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        // A frame cut short: the next frame's bytes land in its payload.
        push_byte(hdr);
        push_byte(ftype);
        push_byte(BYTE_W'($urandom_range(0, 8)));
      end
    end
    // Close on a clean frame so the next phase starts from an empty store.
    push_frame(BYTE_W'($urandom_range(TYPE_MIN, TYPE_MAX)), MEAS_LEN, 1'b0, 1'b0);
    stream_bytes(drain_at);
  endtask

  // The receiver cycles through always ready, random ready and long stretches.
  int unsigned stall_tick = 0;
  int          hold_left = 0;
  logic [1:0]  stall_mode = 2'd0;
  logic        hold_level = 1'b1;

  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 300 == 0) begin
      stall_mode <= 2'($urandom_range(0, 2));
    end
    if (hold_left == 0) begin
      hold_left = $urandom_range(1, 20);
      hold_level = ~hold_level;
    end
    hold_left--;
    case (stall_mode)
      2'd0: begin
        out_ready_i <= 1'b1;
      end
      2'd1: begin
        out_ready_i <= ($urandom_range(0, 99) < 60);
      end
      default: begin
        out_ready_i <= hold_level;
      end
    endcase
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      status_seen[status_o]++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected, status", WORD_W'(status_o), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o != oldest_result.status) begin
          note_mismatch("status", WORD_W'(status_o), WORD_W'(oldest_result.status));
        end
        if (frame_type_o != oldest_result.frame_type) begin
          note_mismatch("frame_type", WORD_W'(frame_type_o),
                        WORD_W'(oldest_result.frame_type));
        end
        if (payload_word_o != oldest_result.payload_word) begin
          note_mismatch("payload_word", payload_word_o, oldest_result.payload_word);
        end
        if (last_o != oldest_result.last) begin
          note_mismatch("last", WORD_W'(last_o), WORD_W'(oldest_result.last));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("typed_length_frame_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] hdr_pick;
    logic [BYTE_W-1:0] tail_pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset header and tail.
    // Measurement with extreme payload bytes.
    byte_plan.push_back(row(8'hAA));
    byte_plan.push_back(row(8'h01));
    byte_plan.push_back(row(8'h04));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(row(8'hFF));
    byte_plan.push_back(row(8'h80));
    byte_plan.push_back(row(8'h7F));
    byte_plan.push_back(row(8'hAF));
    byte_plan.push_back(pin(8'h55, ST_MEAS, 8'h01, 32'h7F80_FF00));
    // Unknown type, empty payload.
    byte_plan.push_back(row(8'hAA));
    byte_plan.push_back(row(8'hFF));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(row(8'h55));
    byte_plan.push_back(pin(8'h55, ST_UNKNOWN, 8'hFF, '0));
    // Known type with the wrong length.
    byte_plan.push_back(row(8'hAA));
    byte_plan.push_back(row(8'h03));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(row(8'hA9));
    byte_plan.push_back(pin(8'h55, ST_BAD_LEN, 8'h03, '0));
    // Wrong checksum byte.
    byte_plan.push_back(row(8'hAA));
    byte_plan.push_back(row(8'h05));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(pin(8'h55, ST_CHECKSUM, 8'h05, '0));
    // Wrong tail byte; the bytes behind the header hold no header and are skipped.
    byte_plan.push_back(row(8'hAA));
    byte_plan.push_back(row(8'h02));
    byte_plan.push_back(row(8'h00));
    byte_plan.push_back(row(8'hA8));
    byte_plan.push_back(pin(8'h00, ST_TAIL, 8'h02, '0));
    stream_bytes(0);

    run_phase(HEADER_RESET, TAIL_RESET, 85, 1'b0, 0);
    run_phase(8'h00, 8'hFF, 75, 1'b1, 0);
    run_phase(8'hFF, 8'h00, 75, 1'b0, 45);
    hdr_pick = BYTE_W'($urandom_range(1, 30));
    tail_pick = other_byte(hdr_pick, hdr_pick);
    run_phase(hdr_pick, tail_pick, 75, 1'b1, 0);
    run_phase(HEADER_RESET, TAIL_RESET, 60, 1'b0, 0);
    settle();

    $display("Sent %0d bytes over six header/tail settings; %0d results checked.",
             bytes_sent, results_checked);
    $display("Statuses seen: meas %0d, length %0d, type %0d, checksum %0d, tail %0d;",
             status_seen[ST_MEAS], status_seen[ST_BAD_LEN], status_seen[ST_UNKNOWN],
             status_seen[ST_CHECKSUM], status_seen[ST_TAIL], " cap hit %0d.", limit_hits);
    if (mismatches == 0) begin
      $display("typed_length_frame_deframer regression: pass");
    end else begin
      $display("typed_length_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
